// ===== design/cau_pkg.sv =====
// Shared widths, opcodes and limits of the complex arithmetic unit.
package cau_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 40;
    localparam int FRAC_BITS = 8;

    localparam logic [63:0] OUT_MAX = 64'd549755813887;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage

// ===== design/complex_arithmetic_unit_top.sv =====
// Pipelined complex ALU: add, subtract, multiply and divide on Q8.8 operands.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+------------------------------------------------
//   input   | i_valid | o_ready | i_opcode, i_a_real, i_a_imag, i_b_real, i_b_imag
//   output  | o_valid | i_ready | o_res_real, o_res_imag, o_divide_by_zero,
//           |         |         | o_saturated
//
// One item may enter every cycle while the skid register is empty. The divider
// resolves one quotient bit per stage.
// Reset is synchronous and clears only the valid bits.
// A stalled output parks one result in a skid register; the pipeline then
// holds until the skid register empties, so nothing is lost or repeated.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_opcode,
    input  logic signed [cau_pkg::IN_W-1:0]    i_a_real,
    input  logic signed [cau_pkg::IN_W-1:0]    i_a_imag,
    input  logic signed [cau_pkg::IN_W-1:0]    i_b_real,
    input  logic signed [cau_pkg::IN_W-1:0]    i_b_imag,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [cau_pkg::OUT_W-1:0]   o_res_real,
    output logic signed [cau_pkg::OUT_W-1:0]   o_res_imag,
    output logic                               o_divide_by_zero,
    output logic                               o_saturated
);
    import cau_pkg::*;

    localparam int SH_W  = 2 * FRAC_BITS;
    localparam int NUM_W = 32 + SH_W;

    typedef struct packed {
        t_op                    op;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic signed [IN_W-1:0] c;
        logic signed [IN_W-1:0] d;
    } t_s0;

    typedef struct packed {
        t_op                     op;
        logic signed [31:0]      ac;
        logic signed [31:0]      bd;
        logic signed [31:0]      ad;
        logic signed [31:0]      bc;
        logic [31:0]             den;
        logic signed [OUT_W-1:0] as_re;
        logic signed [OUT_W-1:0] as_im;
    } t_s1;

    typedef struct packed {
        t_op                     op;
        logic signed [32:0]      num_re;
        logic signed [32:0]      num_im;
        logic [31:0]             den;
        logic signed [OUT_W-1:0] fix_re;
        logic signed [OUT_W-1:0] fix_im;
    } t_s2;

    typedef struct packed {
        t_op                     op;
        logic                    dz;
        logic                    neg_re;
        logic                    neg_im;
        logic [31:0]             den;
        logic [31:0]             rem_re;
        logic [31:0]             rem_im;
        logic [NUM_W-1:0]        dq_re;
        logic [NUM_W-1:0]        dq_im;
        logic signed [OUT_W-1:0] fix_re;
        logic signed [OUT_W-1:0] fix_im;
    } t_dstg;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    dz;
        logic                    sat;
    } t_res;

    logic r_ov, r_sv;

    // Pipeline advances whenever the skid register is empty.
    logic en;
    assign en      = !r_sv;
    assign o_ready = en;

    logic  r_v0, r_v1, r_v2, r_v3;
    t_s0   r_s0;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_dstg r_s3, n_s3;
    logic  r_dv [NUM_W];
    t_dstg r_d  [NUM_W];
    t_dstg n_d  [NUM_W];

    // Stage 1: six products and the add/subtract results.
    always_comb begin
        logic signed [31:0] sq_c;
        logic signed [31:0] sq_d;
        sq_c       = r_s0.c * r_s0.c;
        sq_d       = r_s0.d * r_s0.d;
        n_s1.op    = r_s0.op;
        n_s1.ac    = r_s0.a * r_s0.c;
        n_s1.bd    = r_s0.b * r_s0.d;
        n_s1.ad    = r_s0.a * r_s0.d;
        n_s1.bc    = r_s0.b * r_s0.c;
        n_s1.den   = $unsigned(sq_c) + $unsigned(sq_d);
        if (r_s0.op == OP_SUB) begin
            n_s1.as_re = OUT_W'(r_s0.a) - OUT_W'(r_s0.c);
            n_s1.as_im = OUT_W'(r_s0.b) - OUT_W'(r_s0.d);
        end else begin
            n_s1.as_re = OUT_W'(r_s0.a) + OUT_W'(r_s0.c);
            n_s1.as_im = OUT_W'(r_s0.b) + OUT_W'(r_s0.d);
        end
        n_s1.as_re = n_s1.as_re <<< FRAC_BITS;
        n_s1.as_im = n_s1.as_im <<< FRAC_BITS;
    end

    // Stage 2: product sums for multiply and the divide numerators.
    always_comb begin
        n_s2.op     = r_s1.op;
        n_s2.num_re = 33'(r_s1.ac) + 33'(r_s1.bd);
        n_s2.num_im = 33'(r_s1.bc) - 33'(r_s1.ad);
        n_s2.den    = r_s1.den;
        if (r_s1.op == OP_MUL) begin
            n_s2.fix_re = OUT_W'(r_s1.ac) - OUT_W'(r_s1.bd);
            n_s2.fix_im = OUT_W'(r_s1.ad) + OUT_W'(r_s1.bc);
        end else begin
            n_s2.fix_re = r_s1.as_re;
            n_s2.fix_im = r_s1.as_im;
        end
    end

    // Stage 3: magnitudes and the scaled dividends.
    always_comb begin
        logic [32:0] mag_re;
        logic [32:0] mag_im;
        mag_re        = r_s2.num_re[32] ? 33'(-r_s2.num_re) : 33'(r_s2.num_re);
        mag_im        = r_s2.num_im[32] ? 33'(-r_s2.num_im) : 33'(r_s2.num_im);
        n_s3.op       = r_s2.op;
        n_s3.dz       = (r_s2.den == 32'd0);
        n_s3.neg_re   = r_s2.num_re[32];
        n_s3.neg_im   = r_s2.num_im[32];
        n_s3.den      = r_s2.den;
        n_s3.rem_re   = 32'd0;
        n_s3.rem_im   = 32'd0;
        n_s3.dq_re    = {mag_re[31:0], {SH_W{1'b0}}};
        n_s3.dq_im    = {mag_im[31:0], {SH_W{1'b0}}};
        n_s3.fix_re   = r_s2.fix_re;
        n_s3.fix_im   = r_s2.fix_im;
    end

    // Restoring division: one quotient bit of each part per stage.
    always_comb begin
        t_dstg       prv;
        logic [32:0] t_re;
        logic [32:0] t_im;
        logic        ge_re;
        logic        ge_im;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) prv = r_s3;
            else        prv = r_d[k-1];
            t_re   = {prv.rem_re, prv.dq_re[NUM_W-1]};
            t_im   = {prv.rem_im, prv.dq_im[NUM_W-1]};
            ge_re  = t_re >= {1'b0, prv.den};
            ge_im  = t_im >= {1'b0, prv.den};
            n_d[k] = prv;
            n_d[k].rem_re = ge_re ? 32'(t_re - {1'b0, prv.den}) : t_re[31:0];
            n_d[k].rem_im = ge_im ? 32'(t_im - {1'b0, prv.den}) : t_im[31:0];
            n_d[k].dq_re  = {prv.dq_re[NUM_W-2:0], ge_re};
            n_d[k].dq_im  = {prv.dq_im[NUM_W-2:0], ge_im};
        end
    end

    // Divider stage registers and their valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v3;
            for (int k = 1; k < NUM_W; k++) r_dv[k] <= r_dv[k-1];
        end
        if (en) begin
            r_d <= n_d;
        end
    end

    // Front stages of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_s0 <= '{op: t_op'(i_opcode), a: i_a_real, b: i_a_imag,
                      c: i_b_real, d: i_b_imag};
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    // Final clamp and result selection.
    t_dstg fin;
    t_res  n_res;
    assign fin = r_d[NUM_W-1];

    always_comb begin
        logic [63:0] q_re;
        logic [63:0] q_im;
        logic [63:0] lim_re;
        logic [63:0] lim_im;
        logic        sat_re;
        logic        sat_im;
        q_re   = 64'(fin.dq_re);
        q_im   = 64'(fin.dq_im);
        lim_re = fin.neg_re ? OUT_MAX + 64'd1 : OUT_MAX;
        lim_im = fin.neg_im ? OUT_MAX + 64'd1 : OUT_MAX;
        sat_re = q_re > lim_re;
        sat_im = q_im > lim_im;
        if (sat_re) q_re = lim_re;
        if (sat_im) q_im = lim_im;
        if (fin.neg_re) q_re = 64'd0 - q_re;
        if (fin.neg_im) q_im = 64'd0 - q_im;
        if (fin.op != OP_DIV) begin
            n_res = '{re: fin.fix_re, im: fin.fix_im, dz: 1'b0, sat: 1'b0};
        end else if (fin.dz) begin
            n_res = '{re: '0, im: '0, dz: 1'b1, sat: 1'b0};
        end else begin
            n_res = '{re: OUT_W'(q_re), im: OUT_W'(q_im), dz: 1'b0,
                      sat: sat_re || sat_im};
        end
    end

    // Output register and skid register.
    t_res r_out, r_skid;
    logic push, pop;
    assign push = en && r_dv[NUM_W-1];
    assign pop  = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (pop) begin
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end
        end else if (push) begin
            if (!r_ov || pop) begin
                r_out <= n_res;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= n_res;
                r_sv   <= 1'b1;
            end
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid          = r_ov;
    assign o_res_real       = r_out.re;
    assign o_res_imag       = r_out.im;
    assign o_divide_by_zero = r_out.dz;
    assign o_saturated      = r_out.sat;

    // A held result in the skid register means the output register is full.
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid register full with output empty");

    // A zero divisor returns zero in both parts.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_res_real == '0 && o_res_imag == '0))
        else $error("divide by zero with nonzero result");

    // The two flags never appear together.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_divide_by_zero && o_saturated))
        else $error("both divide flags set");

    // A refused result keeps the skid register full on the next cycle.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_ready) |=> r_sv) else $error("skid result lost");

endmodule

// ===== sim/complex_arithmetic_unit_checker.sv =====
// Checker for the complex arithmetic unit: predicts each result and compares transfers.
module complex_arithmetic_unit_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [1:0]                       i_opcode,
    input  logic signed [cau_pkg::IN_W-1:0]  i_a_real,
    input  logic signed [cau_pkg::IN_W-1:0]  i_a_imag,
    input  logic signed [cau_pkg::IN_W-1:0]  i_b_real,
    input  logic signed [cau_pkg::IN_W-1:0]  i_b_imag,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic signed [cau_pkg::OUT_W-1:0] o_res_real,
    input  logic signed [cau_pkg::OUT_W-1:0] o_res_imag,
    input  logic                             o_divide_by_zero,
    input  logic                             o_saturated,
    output int                               o_fail_count,
    output int                               o_pending
);
    import cau_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    dz;
        logic                    sat;
    } t_cplx_result;

    t_cplx_result expected_results[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Scaled quotient truncated toward zero, clamped to the output range.
    function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                           input logic [63:0] den,
                                                           inout logic clamped);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q   = (mag << (2 * FRAC_BITS)) / den;
        if (num < 0) begin
            if (q > OUT_MAX + 1) begin
                q       = OUT_MAX + 1;
                clamped = 1'b1;
            end
            return -$signed(q);
        end
        if (q > OUT_MAX) begin
            q       = OUT_MAX;
            clamped = 1'b1;
        end
        return $signed(q);
    endfunction

    function automatic t_cplx_result complex_result(input t_op op,
                                                    input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic signed [63:0] c,
                                                    input logic signed [63:0] d);
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic [63:0]        den;
        logic               dz;
        logic               sat;
        t_cplx_result       r;
        re  = 0;
        im  = 0;
        dz  = 1'b0;
        sat = 1'b0;
        case (op)
            OP_ADD: begin
                re = (a + c) <<< FRAC_BITS;
                im = (b + d) <<< FRAC_BITS;
            end
            OP_SUB: begin
                re = (a - c) <<< FRAC_BITS;
                im = (b - d) <<< FRAC_BITS;
            end
            OP_MUL: begin
                re = a * c - b * d;
                im = a * d + b * c;
            end
            default: begin
                den = 64'(c * c) + 64'(d * d);
                if (den == 0) begin
                    dz = 1'b1;
                end else begin
                    re = scaled_quotient(a * c + b * d, den, sat);
                    im = scaled_quotient(b * c - a * d, den, sat);
                end
            end
        endcase
        r.re  = re[OUT_W-1:0];
        r.im  = im[OUT_W-1:0];
        r.dz  = dz;
        r.sat = sat;
        return r;
    endfunction

    // Predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_cplx_result want;
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(complex_result(t_op'(i_opcode), i_a_real, i_a_imag,
                                                      i_b_real, i_b_imag));
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("Unexpected result transfer");
            end else begin
                want = expected_results.pop_front();
                if (want.re !== o_res_real || want.im !== o_res_imag ||
                    want.dz !== o_divide_by_zero || want.sat !== o_saturated) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"Mismatch: expected re=%0d im=%0d dz=%b sat=%b, ",
                                  "got re=%0d im=%0d dz=%b sat=%b"},
                                 want.re, want.im, want.dz, want.sat,
                                 o_res_real, o_res_imag, o_divide_by_zero, o_saturated);
                end
            end
        end
    end

endmodule

// ===== sim/complex_arithmetic_unit_top_tb.sv =====
// Testbench top for the complex arithmetic unit: stimulus, stalls and verdict.
module complex_arithmetic_unit_top_tb;
    import cau_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = OP_ADD;
    logic signed [IN_W-1:0]  i_a_real = '0;
    logic signed [IN_W-1:0]  i_a_imag = '0;
    logic signed [IN_W-1:0]  i_b_real = '0;
    logic signed [IN_W-1:0]  i_b_imag = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [OUT_W-1:0] o_res_real;
    logic signed [OUT_W-1:0] o_res_imag;
    logic        o_divide_by_zero;
    logic        o_saturated;
    int          fail_count;
    int          pending;
    logic        stim_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    complex_arithmetic_unit_top i_dut (.*);

    complex_arithmetic_unit_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_a_real, .i_a_imag,
        .i_b_real, .i_b_imag, .o_valid, .i_ready, .o_res_real, .o_res_imag,
        .o_divide_by_zero, .o_saturated, .o_fail_count(fail_count), .o_pending(pending)
    );

    // Half the time no gap, otherwise mostly short gaps, occasionally long ones.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    // Present one item and hold it until the transfer happens.
    task automatic send_item(input t_op op, input logic [IN_W-1:0] ar, input logic [IN_W-1:0] ai,
                             input logic [IN_W-1:0] br, input logic [IN_W-1:0] bi);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] rand_operand();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver stalls.
    initial begin
        @(negedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(negedge i_clk);
            if ($urandom_range(3) != 0) begin
                i_ready <= 1'b0;
                repeat (gap_length() + 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [IN_W-1:0] edges[4];
        edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: extremes for every operation, zero divisor, small divisors.
        for (int op = 0; op < 4; op++) begin
            send_item(t_op'(op), 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
            send_item(t_op'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_item(t_op'(op), 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        end
        send_item(OP_DIV, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000);
        send_item(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
        send_item(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        send_item(OP_DIV, 16'h8000, 16'h0000, 16'h0000, 16'h0001);
        send_item(OP_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001);
        send_item(OP_DIV, 16'h0100, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(OP_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);

        // Hold off until the pipeline has drained completely.
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random items.
        for (int n = 0; n < 500; n++) begin
            logic [IN_W-1:0] br;
            logic [IN_W-1:0] bi;
            br = rand_operand();
            bi = rand_operand();
            if ($urandom_range(15) == 0) begin
                br = '0;
                bi = '0;
            end else if ($urandom_range(7) == 0) begin
                br = 16'($urandom_range(3));
                bi = '0;
            end
            send_item(t_op'($urandom_range(3)), rand_operand(), rand_operand(), br, bi);
            if (n == 250 && $urandom_range(1) == 0) begin
                send_item(OP_ADD, edges[$urandom_range(3)], edges[$urandom_range(3)],
                          edges[$urandom_range(3)], edges[$urandom_range(3)]);
            end
        end
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * FRAC_BITS + 60) @(negedge i_clk);
        stim_done <= 1'b1;
    end

    initial begin
        wait (stim_done === 1'b1);
        if (fail_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Run limit.
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
